// File: hw/rtl/circle_rect_overlap_test_defines.svh
// Assertion macros shared by the circle / rectangle overlap pipeline.
`ifndef CIRCLE_RECT_OVERLAP_TEST_DEFINES_SVH
`define CIRCLE_RECT_OVERLAP_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define CROT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("overlap pipeline check failed");
`define CROT_ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("overlap pipeline reset check failed");
`else
`define CROT_ASSERT(label, clk, rst, prop)
`define CROT_ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hw/rtl/crot_pkg.sv
// Shared types and constants of the circle / rectangle overlap pipeline.
package crot_pkg;
   localparam int NUM_EDGES = 4;

   typedef enum logic [1:0] {
      EDGE_TOP    = 2'd0,
      EDGE_LEFT   = 2'd1,
      EDGE_BOTTOM = 2'd2,
      EDGE_RIGHT  = 2'd3
   } edge_id_type;

   // Handshake between two pipeline stages, seen from the upstream side.
   typedef struct packed {
      logic valid;
      logic ready;
   } stage_link_type;
endpackage

// File: hw/rtl/crot_prep.sv
// Stage one: containment test and per-edge clamped distances.
module crot_prep
   import crot_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic signed [COORD_BITS-1:0] center_x,
   input  logic signed [COORD_BITS-1:0] center_y,
   input  logic        [COORD_BITS-2:0] radius,
   input  logic signed [COORD_BITS-1:0] rect_left,
   input  logic signed [COORD_BITS-1:0] rect_top,
   input  logic signed [COORD_BITS-1:0] rect_right,
   input  logic signed [COORD_BITS-1:0] rect_bottom,
   output stage_link_type               link,
   input  logic                         link_ready,
   output logic        [COORD_BITS:0]   along_ff [NUM_EDGES],
   output logic        [COORD_BITS:0]   across_ff [NUM_EDGES],
   output logic        [COORD_BITS-2:0] radius_ff,
   output logic                         inbox_ff
);
   localparam int W = COORD_BITS;

   logic                valid_ff, valid_in;
   logic signed [W-1:0] lo [NUM_EDGES];
   logic signed [W-1:0] hi [NUM_EDGES];
   logic signed [W-1:0] ctr [NUM_EDGES];
   logic signed [W-1:0] fix [NUM_EDGES];
   logic signed [W-1:0] fctr [NUM_EDGES];
   logic signed [W-1:0] near [NUM_EDGES];
   logic signed [W:0]   da [NUM_EDGES];
   logic signed [W:0]   db [NUM_EDGES];
   logic        [W:0]   along_in [NUM_EDGES];
   logic        [W:0]   across_in [NUM_EDGES];
   logic signed [W:0]   px_hi, py_hi, px_lo, py_lo, r_ext;
   logic signed [W:0]   x1e, y1e, x2e, y2e;
   logic                inbox_in;

   assign in_ready   = !valid_ff || link_ready;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign link.valid = valid_ff;
   assign link.ready = link_ready;

   // Edge endpoints: top and bottom run along x, left and right along y.
   always_comb begin
      lo[EDGE_TOP]    = (rect_left <= rect_right) ? rect_left : rect_right;
      hi[EDGE_TOP]    = (rect_left <= rect_right) ? rect_right : rect_left;
      lo[EDGE_BOTTOM] = lo[EDGE_TOP];
      hi[EDGE_BOTTOM] = hi[EDGE_TOP];
      lo[EDGE_LEFT]   = (rect_top <= rect_bottom) ? rect_top : rect_bottom;
      hi[EDGE_LEFT]   = (rect_top <= rect_bottom) ? rect_bottom : rect_top;
      lo[EDGE_RIGHT]  = lo[EDGE_LEFT];
      hi[EDGE_RIGHT]  = hi[EDGE_LEFT];
      ctr[EDGE_TOP]    = center_x;
      ctr[EDGE_BOTTOM] = center_x;
      ctr[EDGE_LEFT]   = center_y;
      ctr[EDGE_RIGHT]  = center_y;
      fix[EDGE_TOP]    = rect_top;
      fix[EDGE_BOTTOM] = rect_bottom;
      fix[EDGE_LEFT]   = rect_left;
      fix[EDGE_RIGHT]  = rect_right;
      fctr[EDGE_TOP]    = center_y;
      fctr[EDGE_BOTTOM] = center_y;
      fctr[EDGE_LEFT]   = center_x;
      fctr[EDGE_RIGHT]  = center_x;
   end

   // Closest point on an axis-aligned edge is the center clamped to its span.
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         if (ctr[e] < lo[e]) begin
            near[e] = lo[e];
         end else if (ctr[e] > hi[e]) begin
            near[e] = hi[e];
         end else begin
            near[e] = ctr[e];
         end
         da[e] = {near[e][W-1], near[e]} - {ctr[e][W-1], ctr[e]};
         db[e] = {fix[e][W-1], fix[e]} - {fctr[e][W-1], fctr[e]};
         along_in[e]  = da[e][W] ? (W+1)'(0) - (W+1)'(da[e]) : (W+1)'(da[e]);
         across_in[e] = db[e][W] ? (W+1)'(0) - (W+1)'(db[e]) : (W+1)'(db[e]);
      end
   end

   always_comb begin
      r_ext = {2'b00, radius};
      x1e   = {rect_left[W-1], rect_left};
      y1e   = {rect_top[W-1], rect_top};
      x2e   = {rect_right[W-1], rect_right};
      y2e   = {rect_bottom[W-1], rect_bottom};
      px_hi = {center_x[W-1], center_x} + r_ext;
      py_hi = {center_y[W-1], center_y} + r_ext;
      px_lo = {center_x[W-1], center_x} - r_ext;
      py_lo = {center_y[W-1], center_y} - r_ext;
      inbox_in = (px_hi >= x1e && px_hi <= x2e && py_hi >= y1e && py_hi <= y2e) ||
                 (px_lo >= x1e && px_lo <= x2e && py_lo >= y1e && py_lo <= y2e);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         along_ff  <= along_in;
         across_ff <= across_in;
         radius_ff <= radius;
         inbox_ff  <= inbox_in;
      end
   end
endmodule

// File: hw/rtl/crot_square.sv
// Stage two: squares of the edge distances and of the radius.
module crot_square
   import crot_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  stage_link_type                up,
   output logic                          up_ready,
   input  logic        [COORD_BITS:0]    along [NUM_EDGES],
   input  logic        [COORD_BITS:0]    across [NUM_EDGES],
   input  logic        [COORD_BITS-2:0]  radius,
   input  logic                          inbox,
   output stage_link_type                link,
   input  logic                          link_ready,
   output logic        [2*COORD_BITS+1:0] sq_a_ff [NUM_EDGES],
   output logic        [2*COORD_BITS+1:0] sq_b_ff [NUM_EDGES],
   output logic        [2*COORD_BITS-3:0] rr_ff,
   output logic                          inbox_ff
);
   localparam int W = COORD_BITS;

   logic valid_ff, valid_in;

   assign up_ready   = !valid_ff || link_ready;
   assign valid_in   = up_ready ? up.valid : valid_ff;
   assign link.valid = valid_ff;
   assign link.ready = link_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         for (int e = 0; e < NUM_EDGES; e++) begin
            sq_a_ff[e] <= (2*W+2)'(along[e]) * (2*W+2)'(along[e]);
            sq_b_ff[e] <= (2*W+2)'(across[e]) * (2*W+2)'(across[e]);
         end
         rr_ff    <= (2*W-2)'(radius) * (2*W-2)'(radius);
         inbox_ff <= inbox;
      end
   end
endmodule

// File: hw/rtl/crot_judge.sv
// Stage three: distance compare per edge and the registered result.
module crot_judge
   import crot_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  stage_link_type                 up,
   output logic                           up_ready,
   input  logic        [2*COORD_BITS+1:0] sq_a [NUM_EDGES],
   input  logic        [2*COORD_BITS+1:0] sq_b [NUM_EDGES],
   input  logic        [2*COORD_BITS-3:0] rr,
   input  logic                           inbox,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           hit_ff
);
   localparam int W = COORD_BITS;

   logic                valid_ff, valid_in;
   logic [2*W+2:0]      dist_sum [NUM_EDGES];
   logic [NUM_EDGES-1:0] edge_hit;

   assign up_ready  = !valid_ff || out_ready;
   assign valid_in  = up_ready ? up.valid : valid_ff;
   assign out_valid = valid_ff;

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         dist_sum[e] = (2*W+3)'(sq_a[e]) + (2*W+3)'(sq_b[e]);
         edge_hit[e] = dist_sum[e] < (2*W+3)'(rr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         hit_ff <= inbox || (|edge_hit);
      end
   end
endmodule

// File: hw/rtl/circle_rect_overlap_test.sv
// Circle against axis-aligned rectangle overlap test, three-stage pipeline.
// A transaction on req_ carries a circle (center, radius) and a rectangle
// given by its two corners, and a transaction on rsp_ carries the hit
// flag. One query per clock is taken while the rsp_ side keeps up: the
// three register stages (clamp, square, compare) each move on as soon as
// the stage after it has room, so a stalled rsp_ side backs up only as far
// as needed and bubbles are squeezed out. A query
// hits when the rectangle holds center+(r,r) or center-(r,r) (inclusive
// bounds), or when any edge of the rectangle comes strictly closer than r to
// the center. Swapped corners never satisfy the containment part.
`include "circle_rect_overlap_test_defines.svh"
module circle_rect_overlap_test
   import crot_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // center_x, center_y, radius, rect_left, rect_top, rect_right,
   // rect_bottom, from bit 0 up; zero padded to whole bytes
   input  logic [((7*COORD_BITS-1+7)/8)*8-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit in bit 0, rest zero
   output logic [7:0]            rsp_tdata
);
   localparam int W = COORD_BITS;

   stage_link_type     s1_link, s2_link;
   logic               s2_ready, s3_ready, hit;
   logic [W:0]         along [NUM_EDGES];
   logic [W:0]         across [NUM_EDGES];
   logic [W-2:0]       radius_s1;
   logic               inbox_s1, inbox_s2;
   logic [2*W+1:0]     sq_a [NUM_EDGES];
   logic [2*W+1:0]     sq_b [NUM_EDGES];
   logic [2*W-3:0]     rr;

   // Unpack the request fields from the low bits up.
   crot_prep #(.COORD_BITS(W)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .center_x    (req_tdata[W-1:0]),
      .center_y    (req_tdata[2*W-1:W]),
      .radius      (req_tdata[3*W-2:2*W]),
      .rect_left   (req_tdata[4*W-2:3*W-1]),
      .rect_top    (req_tdata[5*W-2:4*W-1]),
      .rect_right  (req_tdata[6*W-2:5*W-1]),
      .rect_bottom (req_tdata[7*W-2:6*W-1]),
      .link        (s1_link),
      .link_ready  (s2_ready),
      .along_ff    (along),
      .across_ff   (across),
      .radius_ff   (radius_s1),
      .inbox_ff    (inbox_s1)
   );

   crot_square #(.COORD_BITS(W)) u_square (
      .clock      (clock),
      .reset      (reset),
      .up         (s1_link),
      .up_ready   (s2_ready),
      .along      (along),
      .across     (across),
      .radius     (radius_s1),
      .inbox      (inbox_s1),
      .link       (s2_link),
      .link_ready (s3_ready),
      .sq_a_ff    (sq_a),
      .sq_b_ff    (sq_b),
      .rr_ff      (rr),
      .inbox_ff   (inbox_s2)
   );

   crot_judge #(.COORD_BITS(W)) u_judge (
      .clock     (clock),
      .reset     (reset),
      .up        (s2_link),
      .up_ready  (s3_ready),
      .sq_a      (sq_a),
      .sq_b      (sq_b),
      .rr        (rr),
      .inbox     (inbox_s2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hit_ff    (hit)
   );

   assign rsp_tdata = {7'b0, hit};

   // Request side stalls only when stage one holds an item that cannot move.
   `CROT_ASSERT(a_stall_means_full, clock, reset, !req_tready |-> s1_link.valid)
   // An accepted request always lands in stage one.
   `CROT_ASSERT(a_accept_lands, clock, reset, (req_tvalid && req_tready) |=> s1_link.valid)
   // A full stage two that cannot hand off keeps its item.
   `CROT_ASSERT(a_mid_holds, clock, reset,
      (s2_link.valid && !s3_ready) |=> s2_link.valid)
   // Reset empties the pipeline.
   `CROT_ASSERT_RST(a_reset_empty, clock, reset |=> !rsp_tvalid && !s1_link.valid)
endmodule

// File: test/tb_circle_rect_overlap_test.sv
// Testbench for the circle / rectangle overlap pipeline: directed table plus random queries.
module tb_circle_rect_overlap_test;
   localparam int COORD_BITS = 16;
   localparam int REQ_BITS   = ((7*COORD_BITS-1+7)/8)*8;
   localparam int PIPE_DEPTH = 3;
   localparam int NUM_RANDOM = 900;
   localparam int NUM_ROWS   = 22;

   // value in the expected-result column that asks for predict_overlap
   localparam int HIT_PREDICT = 2;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [COORD_BITS-2:0]        radius_type;

   typedef struct packed {
      coord_type  cx;
      coord_type  cy;
      radius_type r;
      coord_type  x1;
      coord_type  y1;
      coord_type  x2;
      coord_type  y2;
   } query_type;

   typedef struct {
      query_type q;
      int        want;   // 0 or 1 when typed in, HIT_PREDICT otherwise
   } query_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;

   logic hit_queue[$];
   int   mismatch_count = 0;
   int   idle_phase = 0;      // 0 none, 1 sender idles, 2 receiver stalls, 3 both
   int   holdoff_cycles = 0;  // long receiver stall, counted in its own process

   circle_rect_overlap_test #(.COORD_BITS(COORD_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // cx, cy, r, x1, y1, x2, y2 from bit 0 up
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // hit in bit 0
   );

   always #10 clock = ~clock;

   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

   // Pack fields from bit 0 up: center_x lowest, rect_bottom highest.
   function automatic logic [REQ_BITS-1:0] pack_query(query_type q);
      logic [REQ_BITS-1:0] d;
      d = '0;
      d[7*COORD_BITS-2:0] = {q.y2, q.x2, q.y1, q.x1, q.r, q.cy, q.cx};
      return d;
   endfunction

   // Closest approach of one axis-aligned edge, strictly inside r*r.
   function automatic bit edge_close(longint cx, longint cy, longint rr,
                                     longint sx, longint sy, longint ex, longint ey);
      longint lx, ly, d, t, px, py, dx, dy;
      lx = ex - sx;
      ly = ey - sy;
      d  = lx*lx + ly*ly;
      t  = -((sx - cx)*lx + (sy - cy)*ly);
      if (t < 0) t = 0;
      else if (t > d) t = d;
      px = sx;
      py = sy;
      // edges are axis aligned, so t/l truncates like t*l/d; SV division truncates to zero
      if (d != 0) begin
         if (lx != 0) px = sx + t / lx;
         if (ly != 0) py = sy + t / ly;
      end
      dx = px - cx;
      dy = py - cy;
      return (dx*dx + dy*dy) < rr;
   endfunction

   function automatic bit corner_in_box(longint px, longint py, query_type q);
      return px >= q.x1 && px <= q.x2 && py >= q.y1 && py <= q.y2;
   endfunction

   function automatic bit predict_overlap(query_type q);
      longint cx, cy, r, rr;
      cx = q.cx;
      cy = q.cy;
      r  = longint'(q.r);
      rr = r * r;
      return corner_in_box(cx + r, cy + r, q) || corner_in_box(cx - r, cy - r, q) ||
             edge_close(cx, cy, rr, q.x1, q.y1, q.x2, q.y1) ||
             edge_close(cx, cy, rr, q.x1, q.y1, q.x1, q.y2) ||
             edge_close(cx, cy, rr, q.x1, q.y2, q.x2, q.y2) ||
             edge_close(cx, cy, rr, q.x2, q.y1, q.x2, q.y2);
   endfunction

   function automatic coord_type rand_coord(int span);
      if (span == 0) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(2*span)) - span);
   endfunction

   // Mostly nearby geometry so hits and misses both occur; some full-range noise.
   function automatic query_type rand_query();
      query_type q;
      int span, sel;
      sel  = $urandom_range(9);
      span = (sel < 2) ? 0 : (sel < 5) ? 200 : (sel < 8) ? 4000 : 30000;
      q.cx = rand_coord(span);
      q.cy = rand_coord(span);
      q.r  = (sel < 2) ? radius_type'($urandom)
                       : radius_type'($urandom_range(span == 0 ? 1 : span));
      q.x1 = rand_coord(span);
      q.y1 = rand_coord(span);
      q.x2 = rand_coord(span);
      q.y2 = rand_coord(span);
      // usually order the corners; leave some swapped
      if ($urandom_range(4) != 0) begin
         if (q.x1 > q.x2) {q.x1, q.x2} = {q.x2, q.x1};
         if (q.y1 > q.y2) {q.y1, q.y2} = {q.y2, q.y1};
      end
      if ($urandom_range(15) == 0) q.x2 = q.x1;  // degenerate edges
      if ($urandom_range(15) == 0) q.y2 = q.y1;
      return q;
   endfunction

   // Offer one transaction; hold valid across back-to-back items.
   task automatic send_query(query_type q, int want);
      while ((idle_phase == 1 && $urandom_range(99) < 79) ||
             (idle_phase == 3 && $urandom_range(99) < 13)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_query(q);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hit_queue.push_back(want == HIT_PREDICT ? predict_overlap(q) : logic'(want));
   endtask

   task automatic wait_drained();
      while (hit_queue.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls by phase, plus the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_tready     <= 1'b0;
      end else if (idle_phase == 2) begin
         rsp_tready <= ($urandom_range(99) >= 79);
      end else if (idle_phase == 3) begin
         rsp_tready <= ($urandom_range(99) >= 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hit_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result hit=%0b", rsp_tdata[0]);
         end else begin
            want = hit_queue.pop_front();
            if (rsp_tdata !== {7'b0, want}) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("hit mismatch: expected %0b got %0b (tdata %h)",
                           want, rsp_tdata[0], rsp_tdata);
            end
         end
      end
   end

   query_row_type directed_rows[NUM_ROWS];

   initial begin
      int cycles;

      // cx, cy, r, x1, y1, x2, y2 : expected
      directed_rows = '{
         // center+(r,r) inside, inclusive on max corner
         '{'{16'sd0, 16'sd0, 15'd5, 16'sd0, 16'sd0, 16'sd5, 16'sd5}, 1},
         // center-(r,r) lands on min corner
         '{'{16'sd10, 16'sd10, 15'd10, 16'sd0, 16'sd0, 16'sd3, 16'sd3}, 1},
         // zero radius, center inside
         '{'{16'sd1, 16'sd1, 15'd0, 16'sd0, 16'sd0, 16'sd2, 16'sd2}, 1},
         // zero radius, center outside: edges never hit
         '{'{16'sd9, 16'sd9, 15'd0, 16'sd0, 16'sd0, 16'sd2, 16'sd2}, 0},
         // far away, small circle
         '{'{16'sd1000, 16'sd1000, 15'd3, 16'sd0, 16'sd0, 16'sd10, 16'sd10}, 0},
         // edge only tangent, but center+(r,r) lands inside the box
         '{'{16'sd5, -16'sd4, 15'd4, 16'sd0, 16'sd0, 16'sd10, 16'sd10}, 1},
         '{'{16'sd5, -16'sd3, 15'd4, 16'sd0, 16'sd0, 16'sd10, 16'sd10}, HIT_PREDICT},
         // zero-size rectangle (all edges degenerate)
         '{'{16'sd3, 16'sd0, 15'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1},
         '{'{16'sd4, 16'sd0, 15'd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
         // swapped corners: containment never, edges still run
         '{'{16'sd5, 16'sd5, 15'd1, 16'sd10, 16'sd10, 16'sd0, 16'sd0}, HIT_PREDICT},
         '{'{16'sd0, 16'sd0, 15'd3, 16'sd10, 16'sd10, -16'sd10, -16'sd10}, HIT_PREDICT},
         '{'{16'sd0, 16'sd0, 15'd2, 16'sd2, 16'sd0, -16'sd2, 16'sd0}, HIT_PREDICT},
         // coordinate extremes
         '{'{-16'sd32768, -16'sd32768, 15'h7fff, 16'sh7fff, 16'sh7fff,
             16'sh7fff, 16'sh7fff}, HIT_PREDICT},
         '{'{16'sh7fff, 16'sh7fff, 15'h7fff, -16'sd32768, -16'sd32768,
             16'sh7fff, 16'sh7fff}, 1},
         '{'{16'sh7fff, -16'sd32768, 15'h7fff, -16'sd32768, 16'sh7fff,
             -16'sd32768, 16'sh7fff}, HIT_PREDICT},
         '{'{-16'sd32768, 16'sh7fff, 15'd0, -16'sd32768, -16'sd32768,
             16'sh7fff, 16'sh7fff}, 1},
         '{'{16'sh7fff, 16'sh7fff, 15'd1, -16'sd32768, -16'sd32768,
             -16'sd32768, -16'sd32768}, 0},
         '{'{16'sh5555, -16'sd21846, 15'h2aaa, -16'sd21846, 16'sh5555,
             16'sh2aaa, -16'sd10923}, HIT_PREDICT},
         // truncating division on a diagonal-free edge, center off to side
         '{'{16'sd7, 16'sd20, 15'd13, 16'sd0, 16'sd0, 16'sd3, 16'sd9}, HIT_PREDICT},
         '{'{-16'sd7, 16'sd4, 15'd8, 16'sd0, 16'sd0, 16'sd3, 16'sd9}, HIT_PREDICT},
         '{'{16'sd100, 16'sd100, 15'd141, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0},
         '{'{16'sd100, 16'sd100, 15'd142, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) send_query(directed_rows[i].q, directed_rows[i].want);

      // random part, walked through the idling phases
      for (int n = 0; n < NUM_RANDOM; n++) begin
         idle_phase = (n / 100) % 4;
         if (n == 450) begin
            // long receiver hold-off while the sender keeps offering
            idle_phase     = 0;
            holdoff_cycles <= 60;
         end
         if (n == 700) begin
            // pause the sender until the pipeline has drained
            req_tvalid <= 1'b0;
            wait_drained();
         end
         send_query(rand_query(), HIT_PREDICT);
      end
      req_tvalid <= 1'b0;

      cycles = 0;
      while (hit_queue.size() != 0 && cycles < 100_000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      if (mismatch_count == 0 && hit_queue.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/crot_pkg.sv
hw/rtl/crot_prep.sv
hw/rtl/crot_square.sv
hw/rtl/crot_judge.sv
hw/rtl/circle_rect_overlap_test.sv
test/tb_circle_rect_overlap_test.sv
